@@ design/adft_pkg.sv @@
// ----------------------------------------------------------------------------
// adft_pkg: shared types and constants of the angle-delta frequency tracker
// Item layouts, configuration and control structs, register indexes and the
// fixed scale factors of the frequency arithmetic.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package adft_pkg;

    // Configuration port geometry.
    localparam int ADDR_W = 4;
    localparam int DATA_W = 32;

    // Register indexes, taken from paddr[3:2].
    localparam logic [1:0] REG_SENSOR_PRESENT = 2'd0;
    localparam logic [1:0] REG_OUTLIER_LIMIT  = 2'd1;
    localparam logic [1:0] REG_EMA_ALPHA      = 2'd2;

    // Item operation codes.
    localparam logic OP_SAMPLE = 1'b0;
    localparam logic OP_CLOSE  = 1'b1;

    // Register reset values.
    localparam logic        SENSOR_PRESENT_RST = 1'b1;
    localparam logic [11:0] OUTLIER_LIMIT_RST  = 12'd512;
    localparam logic [16:0] EMA_ALPHA_RST      = 17'd19661;

    // Alpha of one in Q1.16; larger values are clamped to it.
    localparam logic [16:0] ALPHA_ONE = 17'h10000;

    // Milliseconds per second and the output scale.
    localparam logic [9:0] HZ_MS_SCALE  = 10'd1000;
    localparam logic [6:0] HZ_OUT_SCALE = 7'd100;

    typedef struct packed {
        logic        op;
        logic [11:0] raw_angle;
        logic [15:0] elapsed_ms;
    } adft_meas_t;

    typedef struct packed {
        logic [15:0]        hz_times_100;
        logic signed [11:0] last_delta;
    } adft_rate_t;

    typedef struct packed {
        logic        sensor_present;
        logic [11:0] outlier_limit;
        logic [16:0] ema_alpha;
    } adft_cfg_t;

    // Datapath commands, at most one per controller step.
    typedef struct packed {
        logic load;
        logic delta;
        logic update;
        logic close_abs;
        logic mul;
        logic ema_diff;
        logic ema_mul;
        logic ema_add;
        logic result;
    } adft_cmd_t;

    // Datapath status seen by the controller.
    typedef struct packed {
        logic op;
        logic elapsed_zero;
        logic sensor_present;
        logic div_busy;
    } adft_status_t;

endpackage

@@ design/angle_delta_frequency_tracker_core.sv @@
// ----------------------------------------------------------------------------
// angle_delta_frequency_tracker_core: encoder speed estimator top level
// Angle samples feed a filtered window sum; window-close items turn it into a
// smoothed rotation frequency reported in hundredths of a hertz.
//
//   channel   direction  handshake                 payload
//   meas      in         meas_valid / meas_stall   meas_item  (adft_meas_t)
//   rate      out        rate_valid / rate_stall   rate_item  (adft_rate_t)
//   config    in/out     APB psel/penable/pready   paddr, pwdata, prdata
//
// One item is in work at a time; every item yields exactly one result.
// An angle sample passes the delta and update steps; an item with the sensor
// absent goes straight to the result, and a window close with zero elapsed
// time goes to the result after the magnitude step. Any other window close
// runs the serial divider, which forms one quotient bit of the 58 - ANGLE_BITS
// bit scaled sum per cycle, and then the EMA steps.
// The result register frees the controller: the next item is taken while a
// result waits; a held rate_stall only blocks the following result.
// Reset is asynchronous and active low; no clearing pass is needed.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module angle_delta_frequency_tracker_core #(
    parameter int unsigned ANGLE_BITS = 12
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [adft_pkg::ADDR_W-1:0]   paddr,
    input  logic [adft_pkg::DATA_W-1:0]   pwdata,
    output logic [adft_pkg::DATA_W-1:0]   prdata,
    output logic                          pready,
    input  logic                          meas_valid,
    output logic                          meas_stall,
    input  adft_pkg::adft_meas_t          meas_item,
    output logic                          rate_valid,
    input  logic                          rate_stall,
    output adft_pkg::adft_rate_t          rate_item
);
    import adft_pkg::*;

    adft_cfg_t    cfg;
    adft_cmd_t    cmd;
    adft_status_t status;

    // Configuration registers.
    adft_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Sequencing controller.
    adft_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .meas_valid (meas_valid),
        .meas_stall (meas_stall),
        .rate_valid (rate_valid),
        .rate_stall (rate_stall),
        .status     (status),
        .cmd        (cmd)
    );

    // Arithmetic datapath.
    adft_dpath #(
        .ANGLE_BITS (ANGLE_BITS)
    ) u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .meas_item (meas_item),
        .cmd       (cmd),
        .cfg       (cfg),
        .status    (status),
        .rate_item (rate_item)
    );

endmodule

@@ design/adft_regs.sv @@
// ----------------------------------------------------------------------------
// adft_regs: configuration register file
// APB-style slave holding sensor_present, outlier_limit and ema_alpha.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module adft_regs (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [adft_pkg::ADDR_W-1:0]   paddr,
    input  logic [adft_pkg::DATA_W-1:0]   pwdata,
    output logic [adft_pkg::DATA_W-1:0]   prdata,
    output logic                          pready,
    output adft_pkg::adft_cfg_t           cfg
);
    import adft_pkg::*;

    adft_cfg_t  cfg_reg;
    adft_cfg_t  cfg_next;
    logic [1:0] reg_idx;

    assign reg_idx = paddr[ADDR_W-1:2];
    assign pready  = 1'b1;
    assign cfg     = cfg_reg;

    // Write decode; the access phase commits the data.
    always_comb
    begin
        cfg_next = cfg_reg;
        if (psel && penable && pwrite)
        begin
            unique case (reg_idx)
                REG_SENSOR_PRESENT: cfg_next.sensor_present = pwdata[0];
                REG_OUTLIER_LIMIT:  cfg_next.outlier_limit  = pwdata[11:0];
                REG_EMA_ALPHA:      cfg_next.ema_alpha      = pwdata[16:0];
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    // Read mux.
    always_comb
    begin
        unique case (reg_idx)
            REG_SENSOR_PRESENT: prdata = {{(DATA_W-1){1'b0}}, cfg_reg.sensor_present};
            REG_OUTLIER_LIMIT:  prdata = {{(DATA_W-12){1'b0}}, cfg_reg.outlier_limit};
            REG_EMA_ALPHA:      prdata = {{(DATA_W-17){1'b0}}, cfg_reg.ema_alpha};
            default:            prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.sensor_present <= SENSOR_PRESENT_RST;
            cfg_reg.outlier_limit  <= OUTLIER_LIMIT_RST;
            cfg_reg.ema_alpha      <= EMA_ALPHA_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

@@ design/adft_ctrl.sv @@
// ----------------------------------------------------------------------------
// adft_ctrl: sequencing controller
// Accepts one item at a time, steps the datapath through the sample or
// window-close sequence and owns the result valid flag.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module adft_ctrl (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    meas_valid,
    output logic                    meas_stall,
    output logic                    rate_valid,
    input  logic                    rate_stall,
    input  adft_pkg::adft_status_t  status,
    output adft_pkg::adft_cmd_t     cmd
);
    import adft_pkg::*;

    typedef enum logic [3:0] {
        IDLE,
        DECIDE,
        SAMPLE_DELTA,
        SAMPLE_UPDATE,
        CLOSE_ABS,
        CLOSE_MUL,
        CLOSE_DIV,
        EMA_DIFF,
        EMA_MUL,
        EMA_ADD,
        RESULT
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   rate_valid_reg;
    logic   rate_valid_next;
    logic   out_free;

    assign meas_stall = (state_reg != IDLE);
    assign rate_valid = rate_valid_reg;
    assign out_free   = !rate_valid_reg || !rate_stall;

    // Commands decoded from the current step.
    always_comb
    begin
        cmd           = '0;
        cmd.load      = (state_reg == IDLE) && meas_valid;
        cmd.delta     = (state_reg == SAMPLE_DELTA);
        cmd.update    = (state_reg == SAMPLE_UPDATE);
        cmd.close_abs = (state_reg == CLOSE_ABS);
        cmd.mul       = (state_reg == CLOSE_MUL);
        cmd.ema_diff  = (state_reg == EMA_DIFF);
        cmd.ema_mul   = (state_reg == EMA_MUL);
        cmd.ema_add   = (state_reg == EMA_ADD);
        cmd.result    = (state_reg == RESULT) && out_free;
    end

    // Next step.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            IDLE:
            begin
                if (meas_valid)
                begin
                    state_next = DECIDE;
                end
            end
            DECIDE:
            begin
                if (!status.sensor_present)
                begin
                    state_next = RESULT;
                end
                else
                begin
                    unique case (status.op)
                        OP_SAMPLE: state_next = SAMPLE_DELTA;
                        OP_CLOSE:  state_next = CLOSE_ABS;
                    endcase
                end
            end
            SAMPLE_DELTA:  state_next = SAMPLE_UPDATE;
            SAMPLE_UPDATE: state_next = RESULT;
            CLOSE_ABS:     state_next = status.elapsed_zero ? RESULT : CLOSE_MUL;
            CLOSE_MUL:     state_next = CLOSE_DIV;
            CLOSE_DIV:
            begin
                if (!status.div_busy)
                begin
                    state_next = EMA_DIFF;
                end
            end
            EMA_DIFF:      state_next = EMA_MUL;
            EMA_MUL:       state_next = EMA_ADD;
            EMA_ADD:       state_next = RESULT;
            RESULT:
            begin
                if (out_free)
                begin
                    state_next = IDLE;
                end
            end
            default:       state_next = IDLE;
        endcase
    end

    // Result valid: set when the output register loads, cleared when taken.
    always_comb
    begin
        rate_valid_next = rate_valid_reg;
        if (cmd.result)
        begin
            rate_valid_next = 1'b1;
        end
        else if (rate_valid_reg && !rate_stall)
        begin
            rate_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= IDLE;
            rate_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            rate_valid_reg <= rate_valid_next;
        end
    end

endmodule

@@ design/adft_dpath.sv @@
// ----------------------------------------------------------------------------
// adft_dpath: tracker datapath
// Angle delta wrap and outlier filter, saturating window sum, frequency
// scaling with a bit-serial divider, EMA smoothing and the output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module adft_dpath #(
    parameter int unsigned ANGLE_BITS = 12
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  adft_pkg::adft_meas_t    meas_item,
    input  adft_pkg::adft_cmd_t     cmd,
    input  adft_pkg::adft_cfg_t     cfg,
    output adft_pkg::adft_status_t  status,
    output adft_pkg::adft_rate_t    rate_item
);
    import adft_pkg::*;

    // Delta width: the raw difference spans almost two full turns.
    localparam int DW  = ANGLE_BITS + 2;
    // Scale of counts to Q16.16 turns per second: 1000 << (16 - ANGLE_BITS).
    localparam int SW  = 26 - ANGLE_BITS;
    localparam int PW  = 32 + SW;
    localparam int CW  = $clog2(PW + 1);
    localparam int EPW = 51;

    localparam logic signed [DW-1:0] ANG_HALF = DW'(2 ** (ANGLE_BITS - 1));
    localparam logic signed [DW-1:0] ANG_FULL = DW'(2 ** ANGLE_BITS);
    localparam logic [SW-1:0]        HZ_SCALE = SW'(HZ_MS_SCALE) << (16 - ANGLE_BITS);

    // Architectural state.
    logic [ANGLE_BITS-1:0]  prev_reg;
    logic                   first_reg;
    logic signed [31:0]     sum_reg;
    logic [31:0]            filt_reg;
    logic signed [11:0]     kept_reg;
    logic [CW-1:0]          cnt_reg;

    // Working registers.
    adft_meas_t             meas_reg;
    logic signed [DW-1:0]   delta_reg;
    logic [31:0]            mag_reg;
    logic [PW-1:0]          dvd_reg;
    logic [15:0]            rem_reg;
    logic [16:0]            alpha_reg;
    logic signed [32:0]     diff_reg;
    logic signed [EPW-1:0]  eprod_reg;
    adft_rate_t             rate_reg;

    logic [ANGLE_BITS-1:0]  raw_m;
    logic signed [DW-1:0]   diff_raw;
    logic signed [DW-1:0]   delta_wrap;
    logic signed [31:0]     d32;
    logic signed [31:0]     lim32;
    logic                   delta_ok;
    logic signed [32:0]     sum33;
    logic signed [31:0]     sum_sat;
    logic [16:0]            rem_shift;
    logic [16:0]            divisor;
    logic                   q_bit;
    logic [31:0]            hz_sat;
    logic signed [EPW-1:0]  ema_sum;
    logic [38:0]            out_prod;

    assign status.op             = meas_reg.op;
    assign status.elapsed_zero   = (meas_reg.elapsed_ms == 16'd0);
    assign status.sensor_present = cfg.sensor_present;
    assign status.div_busy       = (cnt_reg != '0);
    assign rate_item             = rate_reg;

    // Angle wrap into -half..+half counts.
    always_comb
    begin
        raw_m    = ANGLE_BITS'(meas_reg.raw_angle);
        diff_raw = $signed({2'b00, raw_m}) - $signed({2'b00, prev_reg});
        if (diff_raw > ANG_HALF)
        begin
            delta_wrap = diff_raw - ANG_FULL;
        end
        else if (diff_raw < -ANG_HALF)
        begin
            delta_wrap = diff_raw + ANG_FULL;
        end
        else
        begin
            delta_wrap = diff_raw;
        end
    end

    // Outlier window and saturating accumulate.
    always_comb
    begin
        d32      = 32'(delta_reg);
        lim32    = $signed({20'd0, cfg.outlier_limit});
        delta_ok = (d32 > -lim32) && (d32 < lim32);
        sum33    = $signed({sum_reg[31], sum_reg}) + $signed({d32[31], d32});
        if (sum33[32] != sum33[31])
        begin
            sum_sat = sum33[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        end
        else
        begin
            sum_sat = sum33[31:0];
        end
    end

    // One restoring divide step per cycle.
    always_comb
    begin
        divisor   = {1'b0, meas_reg.elapsed_ms};
        rem_shift = {rem_reg, dvd_reg[PW-1]};
        q_bit     = (rem_shift >= divisor);
    end

    // Smoothing: filt + floor(alpha * (hz - filt) / 2^16).
    always_comb
    begin
        hz_sat   = (|dvd_reg[PW-1:32]) ? 32'hFFFF_FFFF : dvd_reg[31:0];
        ema_sum  = $signed({19'd0, filt_reg}) + (eprod_reg >>> 16);
        out_prod = filt_reg * HZ_OUT_SCALE;
    end

    // State with reset values.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_reg  <= '0;
            first_reg <= 1'b1;
            sum_reg   <= '0;
            filt_reg  <= '0;
            kept_reg  <= '0;
            cnt_reg   <= '0;
        end
        else
        begin
            if (cmd.update)
            begin
                prev_reg  <= raw_m;
                first_reg <= 1'b0;
                if (!first_reg && delta_ok)
                begin
                    sum_reg  <= sum_sat;
                    kept_reg <= d32[11:0];
                end
            end
            if (cmd.close_abs)
            begin
                sum_reg <= '0;
            end
            if (cmd.mul)
            begin
                cnt_reg <= CW'(PW);
            end
            else if (cnt_reg != '0)
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
            if (cmd.ema_add)
            begin
                filt_reg <= ema_sum[31:0];
            end
        end
    end

    // Working registers, no reset needed.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            meas_reg <= meas_item;
        end
        if (cmd.delta)
        begin
            delta_reg <= delta_wrap;
        end
        if (cmd.close_abs)
        begin
            mag_reg <= sum_reg[31] ? (32'd0 - sum_reg) : sum_reg;
        end
        if (cmd.mul)
        begin
            dvd_reg <= mag_reg * HZ_SCALE;
            rem_reg <= '0;
        end
        else if (cnt_reg != '0)
        begin
            dvd_reg <= {dvd_reg[PW-2:0], q_bit};
            rem_reg <= q_bit ? 16'(rem_shift - divisor) : rem_shift[15:0];
        end
        if (cmd.ema_diff)
        begin
            diff_reg  <= $signed({1'b0, hz_sat}) - $signed({1'b0, filt_reg});
            alpha_reg <= (cfg.ema_alpha > ALPHA_ONE) ? ALPHA_ONE : cfg.ema_alpha;
        end
        if (cmd.ema_mul)
        begin
            eprod_reg <= diff_reg * $signed({1'b0, alpha_reg});
        end
        if (cmd.result)
        begin
            rate_reg.hz_times_100 <= (|out_prod[38:32]) ? 16'hFFFF : out_prod[31:16];
            rate_reg.last_delta   <= kept_reg;
        end
    end

endmodule

@@ design/adft_checker.sv @@
// ----------------------------------------------------------------------------
// adft_checker: port-level checks for the tracker top level
// Tracks items in flight and checks busy, result and config port behavior.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module adft_checker (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  pready,
    input  logic                  meas_valid,
    input  logic                  meas_stall,
    input  logic                  rate_valid,
    input  logic                  rate_stall,
    input  adft_pkg::adft_rate_t  rate_item
);
    import adft_pkg::*;

    logic [1:0] pend_reg;
    logic [1:0] pend_next;
    logic       meas_acc;
    logic       rate_acc;

    assign meas_acc = meas_valid && !meas_stall;
    assign rate_acc = rate_valid && !rate_stall;

    // Items accepted but not yet delivered.
    always_comb
    begin
        pend_next = pend_reg + {1'b0, meas_acc} - {1'b0, rate_acc};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= '0;
        end
        else
        begin
            pend_reg <= pend_next;
        end
    end

    // A stalled result stays put.
    a_rate_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rate_valid && rate_stall |=> rate_valid && $stable(rate_item))
        else $error("stalled result changed or dropped");

    // The block is busy right after taking an item.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        meas_acc |=> meas_stall)
        else $error("second item taken while one is in work");

    // A result is only shown for an item that was taken.
    a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
        rate_valid |-> pend_reg != 2'd0)
        else $error("result without a pending item");

    // At most one item in work plus one waiting result.
    a_pend_bound: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg != 2'd3)
        else $error("too many items in flight");

    // The config port never inserts wait states.
    a_pready: assert property (@(posedge clk) disable iff (!rst_n)
        pready)
        else $error("pready dropped");

endmodule

bind angle_delta_frequency_tracker_core adft_checker u_adft_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .pready     (pready),
    .meas_valid (meas_valid),
    .meas_stall (meas_stall),
    .rate_valid (rate_valid),
    .rate_stall (rate_stall),
    .rate_item  (rate_item)
);
